>>> rtl/msl_pkg.sv
// ----------------------------------------------------------------------------
// msl_pkg
// Shared widths, mode codes and types of the mesh step length limiter.
// ----------------------------------------------------------------------------
package msl_pkg;

    localparam int W_IN   = 32;   // input coordinate
    localparam int W_DIF  = 33;   // difference of two coordinates
    localparam int W_PROD = 66;   // one 33x33 product
    localparam int W_ABC  = 68;   // quadratic coefficients, signed
    localparam int W_MAG  = 67;   // coefficient magnitude
    localparam int W_K    = 82;   // 10000 times a magnitude
    localparam int W_CNT  = 24;   // triangle counter
    localparam int W_Q    = 31;   // step in Q1.30
    localparam int W_OUT  = 30;   // emitted step
    localparam int W_SQR  = 134;  // product of two magnitudes
    localparam int W_D    = 136;  // discriminant, signed
    localparam int W_RAD  = 194;  // radicand d * 2^60
    localparam int W_ROOT = 97;   // integer root of the radicand
    localparam int W_SREM = 100;  // root remainder
    localparam int W_NUM  = 100;  // division numerator, signed
    localparam int W_DEN  = 67;   // division denominator
    localparam int W_DSH  = 98;   // shifted denominator
    localparam int Q_FRAC = 30;

    localparam logic [W_Q-1:0] ONE_Q30 = 31'h4000_0000;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_LIN  = 2'd1;
    localparam logic [1:0] MODE_LOW  = 2'd2;
    localparam logic [1:0] MODE_HIGH = 2'd3;

    typedef struct packed {
        logic [1:0]              mode;
        logic signed [W_ABC-1:0] a;
        logic signed [W_ABC-1:0] b;
        logic signed [W_ABC-1:0] c;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [W_MAG-1:0] mag(input logic signed [W_ABC-1:0] v);
        logic signed [W_ABC-1:0] n;
        n = -v;
        return v[W_ABC-1] ? n[W_MAG-1:0] : v[W_MAG-1:0];
    endfunction

    // 10000 = 2^13 + 2^10 + 2^9 + 2^8 + 2^4
    function automatic logic [W_K-1:0] times10k(input logic [W_MAG-1:0] x);
        logic [W_K-1:0] xe;
        xe = W_K'(x);
        return (xe << 13) + (xe << 10) + (xe << 9) + (xe << 8) + (xe << 4);
    endfunction

endpackage

>>> rtl/msl_front.sv
// ----------------------------------------------------------------------------
// msl_front
// Takes one triangle, builds the area coefficients a, b, c with one shared
// multiplier and classifies the triangle into a job for the back end.
// ----------------------------------------------------------------------------
module msl_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [31:0]           i_pos0_x,
    input  logic signed [31:0]           i_pos0_y,
    input  logic signed [31:0]           i_pos1_x,
    input  logic signed [31:0]           i_pos1_y,
    input  logic signed [31:0]           i_pos2_x,
    input  logic signed [31:0]           i_pos2_y,
    input  logic signed [31:0]           i_dir0_x,
    input  logic signed [31:0]           i_dir0_y,
    input  logic signed [31:0]           i_dir1_x,
    input  logic signed [31:0]           i_dir1_y,
    input  logic signed [31:0]           i_dir2_x,
    input  logic signed [31:0]           i_dir2_y,
    output logic                         o_push,
    output msl_pkg::t_job                o_job,
    input  msl_pkg::t_qstat              i_qstat
);
    import msl_pkg::*;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_MUL  = 3'd1;
    localparam logic [2:0] F_ABS  = 3'd2;
    localparam logic [2:0] F_CLS  = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;

    localparam logic [1:0] TGT_A = 2'd0;
    localparam logic [1:0] TGT_B = 2'd1;
    localparam logic [1:0] TGT_C = 2'd2;

    localparam logic [3:0] N_PROD = 4'd10;

    logic [2:0] r_state, n_state;
    logic [3:0] r_step;
    logic signed [W_IN-1:0] r_x0, r_y0, r_x1, r_y1, r_x2, r_y2;
    logic signed [W_IN-1:0] r_m0x, r_m0y, r_m1x, r_m1y, r_m2x, r_m2y;
    logic signed [W_PROD-1:0] r_prod;
    logic [1:0] r_ptgt;
    logic r_psub;
    logic signed [W_ABC-1:0] r_a, r_b, r_c;
    logic [W_MAG-1:0] r_ma, r_mb, r_mc;
    t_job r_job;

    logic signed [W_DIF-1:0] w_opa, w_opb;
    logic signed [W_PROD-1:0] w_prod;
    logic [1:0] w_tgt;
    logic w_sub;
    logic signed [W_ABC-1:0] w_pext;
    logic [W_K-1:0] w_ka, w_kb, w_sum;
    logic signed [W_ABC-1:0] w_na, w_nb, w_nc;
    logic [1:0] w_mode;

    function automatic logic signed [W_DIF-1:0] dif(input logic signed [W_IN-1:0] p,
                                                    input logic signed [W_IN-1:0] q);
        return $signed({p[W_IN-1], p}) - $signed({q[W_IN-1], q});
    endfunction

    function automatic logic signed [W_DIF-1:0] ext(input logic signed [W_IN-1:0] p);
        return $signed({p[W_IN-1], p});
    endfunction

    // operand schedule: a from the move vectors, c from the positions, b mixed
    always_comb begin
        w_opa = '0;
        w_opb = '0;
        w_tgt = TGT_A;
        w_sub = 1'b0;
        case (r_step)
            4'd0: begin w_opa = dif(r_m1x, r_m0x); w_opb = dif(r_m2y, r_m0y); end
            4'd1: begin
                w_opa = dif(r_m1y, r_m0y); w_opb = dif(r_m2x, r_m0x); w_sub = 1'b1;
            end
            4'd2: begin
                w_opa = dif(r_x1, r_x0); w_opb = dif(r_y2, r_y0); w_tgt = TGT_C;
            end
            4'd3: begin
                w_opa = dif(r_y1, r_y0); w_opb = dif(r_x2, r_x0); w_tgt = TGT_C;
                w_sub = 1'b1;
            end
            4'd4: begin w_opa = ext(r_m0x); w_opb = dif(r_y1, r_y2); w_tgt = TGT_B; end
            4'd5: begin
                w_opa = ext(r_m0y); w_opb = dif(r_x1, r_x2); w_tgt = TGT_B; w_sub = 1'b1;
            end
            4'd6: begin w_opa = ext(r_m1x); w_opb = dif(r_y2, r_y0); w_tgt = TGT_B; end
            4'd7: begin
                w_opa = ext(r_m1y); w_opb = dif(r_x2, r_x0); w_tgt = TGT_B; w_sub = 1'b1;
            end
            4'd8: begin w_opa = ext(r_m2x); w_opb = dif(r_y0, r_y1); w_tgt = TGT_B; end
            4'd9: begin
                w_opa = ext(r_m2y); w_opb = dif(r_x0, r_x1); w_tgt = TGT_B; w_sub = 1'b1;
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
    end

    assign w_prod = w_opa * w_opb;
    assign w_pext = $signed({{(W_ABC-W_PROD){r_prod[W_PROD-1]}}, r_prod});

    // classification
    always_comb begin
        w_sum = W_K'(r_mb) + W_K'(r_mc);
        w_ka  = times10k(r_ma);
        w_kb  = times10k(r_mb);
        w_na  = r_a[W_ABC-1] ? -r_a : r_a;
        w_nb  = r_a[W_ABC-1] ? -r_b : r_b;
        w_nc  = r_a[W_ABC-1] ? -r_c : r_c;
        w_mode = MODE_NONE;
        if (w_sum == '0) begin
            w_mode = MODE_NONE;
        end else if (w_ka < w_sum) begin
            if (w_kb < W_K'(r_mc)) begin
                w_mode = MODE_NONE;
            end else if (r_c != '0 && r_c[W_ABC-1] == r_b[W_ABC-1]) begin
                w_mode = MODE_NONE;
            end else begin
                w_mode = MODE_LIN;
            end
        end else begin
            if ((w_nb[W_ABC-1] || w_nb == '0) && !w_nc[W_ABC-1]) begin
                w_mode = MODE_LOW;
            end else if (w_nb[W_ABC-1] || w_nc[W_ABC-1]) begin
                w_mode = MODE_HIGH;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_valid) n_state = F_MUL;
            F_MUL:  if (r_step == N_PROD) n_state = F_ABS;
            F_ABS:  n_state = F_CLS;
            F_CLS:  n_state = F_PUSH;
            F_PUSH: if (!i_qstat.full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_valid) begin
            r_x0 <= i_pos0_x; r_y0 <= i_pos0_y;
            r_x1 <= i_pos1_x; r_y1 <= i_pos1_y;
            r_x2 <= i_pos2_x; r_y2 <= i_pos2_y;
            r_m0x <= i_dir0_x; r_m0y <= i_dir0_y;
            r_m1x <= i_dir1_x; r_m1y <= i_dir1_y;
            r_m2x <= i_dir2_x; r_m2y <= i_dir2_y;
            r_step <= '0;
            r_a <= '0;
            r_b <= '0;
            r_c <= '0;
        end
        if (r_state == F_MUL) begin
            r_step <= r_step + 4'd1;
            r_prod <= w_prod;
            r_ptgt <= w_tgt;
            r_psub <= w_sub;
            // accumulate the product issued in the previous cycle
            if (r_step != '0) begin
                case (r_ptgt)
                    TGT_A:   r_a <= r_psub ? r_a - w_pext : r_a + w_pext;
                    TGT_B:   r_b <= r_psub ? r_b - w_pext : r_b + w_pext;
                    default: r_c <= r_psub ? r_c - w_pext : r_c + w_pext;
                endcase
            end
        end
        if (r_state == F_ABS) begin
            r_ma <= mag(r_a);
            r_mb <= mag(r_b);
            r_mc <= mag(r_c);
        end
        if (r_state == F_CLS) begin
            r_job.mode <= w_mode;
            if (w_mode == MODE_LIN) begin
                r_job.a <= r_a;
                r_job.b <= r_b;
                r_job.c <= r_c;
            end else begin
                r_job.a <= w_na;
                r_job.b <= w_nb;
                r_job.c <= w_nc;
            end
        end
    end

    assign o_stall = (r_state != F_IDLE);
    assign o_push  = (r_state == F_PUSH) && !i_qstat.full;
    assign o_job   = r_job;

endmodule

>>> rtl/msl_queue.sv
// ----------------------------------------------------------------------------
// msl_queue
// Two-entry job queue between the classifier and the step solver.
// ----------------------------------------------------------------------------
module msl_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  msl_pkg::t_job     i_job,
    input  logic              i_pop,
    output msl_pkg::t_job     o_job,
    output msl_pkg::t_qstat   o_qstat
);
    import msl_pkg::*;

    t_job r_mem [0:1];
    logic r_wr, r_rd;
    logic [1:0] r_fill;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_fill <= '0;
        end else begin
            if (i_push) r_wr <= !r_wr;
            if (i_pop)  r_rd <= !r_rd;
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    assign o_job         = r_mem[r_rd];
    assign o_qstat.full  = (r_fill == 2'd2);
    assign o_qstat.empty = (r_fill == 2'd0);

endmodule

>>> rtl/msl_back.sv
// ----------------------------------------------------------------------------
// msl_back
// Solves one job for its first collapse step with a serial squarer, a
// bit-per-cycle square root and a restoring divider, keeps the running
// minimum and emits half of it after each group of triangles.
// ----------------------------------------------------------------------------
module msl_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  msl_pkg::t_qstat      i_qstat,
    input  msl_pkg::t_job        i_job,
    output logic                 o_pop,
    input  logic                 i_cfg_we,
    input  logic [23:0]          i_cfg_wdata,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [29:0]          o_step_length
);
    import msl_pkg::*;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_MUL  = 3'd1;
    localparam logic [2:0] B_DSGN = 3'd2;
    localparam logic [2:0] B_SQRT = 3'd3;
    localparam logic [2:0] B_NUM  = 3'd4;
    localparam logic [2:0] B_DIV  = 3'd5;
    localparam logic [2:0] B_FIN  = 3'd6;

    localparam logic [6:0] MUL_LAST  = 7'(W_MAG - 1);
    localparam logic [6:0] SQRT_LAST = 7'(W_ROOT - 1);
    localparam logic [6:0] DIV_FIRST = 7'(W_Q - 1);

    logic [2:0] r_state;
    logic [6:0] r_cnt;
    t_job r_job;
    logic [W_SQR-1:0] r_mcs, r_accs, r_mcp, r_accp;
    logic [W_MAG-1:0] r_mls, r_mlp;
    logic [W_RAD-1:0] r_rad;
    logic [W_ROOT-1:0] r_root;
    logic [W_SREM-1:0] r_srem;
    logic [W_NUM-2:0] r_drem;
    logic [W_DSH-1:0] r_dsh;
    logic [W_Q-1:0] r_q, r_rm;
    logic r_upd;
    logic [W_CNT-1:0] r_seen, r_count;
    logic r_ovalid;
    logic [W_OUT-1:0] r_oval;

    logic signed [W_D-1:0] w_d;
    logic [W_SREM-1:0] w_t, w_trial;
    logic signed [W_NUM-1:0] w_num, w_sb, w_root;
    logic [W_DEN-1:0] w_den;
    logic w_ge;
    logic [W_Q-1:0] w_rmn;
    logic [W_CNT-1:0] w_seen;
    logic w_emit, w_busy;

    always_comb begin
        // d = b^2 - 4ac, a already made positive
        if (r_job.c[W_ABC-1]) begin
            w_d = $signed(W_D'(r_accs)) + $signed(W_D'(r_accp) << 2);
        end else begin
            w_d = $signed(W_D'(r_accs)) - $signed(W_D'(r_accp) << 2);
        end
        w_t     = {r_srem[W_SREM-3:0], r_rad[W_RAD-1 -: 2]};
        w_trial = (W_SREM'(r_root) << 2) | W_SREM'(1);
        w_sb    = $signed({{(W_NUM-W_ABC){r_job.b[W_ABC-1]}}, r_job.b}) <<< Q_FRAC;
        w_root  = $signed(W_NUM'(r_root));
        if (r_job.mode == MODE_LIN) begin
            w_num = $signed(W_NUM'(mag(r_job.c)) << Q_FRAC);
            w_den = mag(r_job.b);
        end else if (r_job.mode == MODE_LOW) begin
            // smaller root: l <= -ceil(sqrt)
            w_num = -w_root - $signed(W_NUM'(r_srem != '0)) - w_sb;
            w_den = W_DEN'(r_job.a) << 1;
        end else begin
            w_num = w_root - w_sb;
            w_den = W_DEN'(r_job.a) << 1;
        end
        w_ge   = {1'b0, r_drem} >= {1'b0, r_dsh};
        w_rmn  = (r_upd && r_q < r_rm) ? r_q : r_rm;
        w_seen = r_seen + 24'd1;
        w_emit = (w_seen >= r_count);
        w_busy = r_ovalid && i_stall;
    end

    assign o_pop = (r_state == B_IDLE) && !i_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_rm     <= ONE_Q30;
            r_seen   <= '0;
            r_count  <= 24'd1;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) r_count <= i_cfg_wdata;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                B_IDLE: begin
                    if (!i_qstat.empty) begin
                        unique case (i_job.mode)
                            MODE_NONE: r_state <= B_FIN;
                            MODE_LIN:  r_state <= B_NUM;
                            default:   r_state <= B_MUL;
                        endcase
                    end
                end
                B_MUL:  if (r_cnt == MUL_LAST) r_state <= B_DSGN;
                B_DSGN: r_state <= w_d[W_D-1] ? B_FIN : B_SQRT;
                B_SQRT: if (r_cnt == SQRT_LAST) r_state <= B_NUM;
                B_NUM:  r_state <= w_num[W_NUM-1] ? B_FIN : B_DIV;
                B_DIV:  if (r_cnt == '0) r_state <= B_FIN;
                B_FIN: begin
                    if (!(w_emit && w_busy)) begin
                        r_state <= B_IDLE;
                        if (w_emit) begin
                            r_oval   <= w_rmn[W_Q-1:1];
                            r_ovalid <= 1'b1;
                            r_rm     <= ONE_Q30;
                            r_seen   <= '0;
                        end else begin
                            r_rm   <= w_rmn;
                            r_seen <= w_seen;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_job <= i_job;
                r_upd <= 1'b0;
                r_cnt <= '0;
                r_mcs <= W_SQR'(mag(i_job.b));
                r_mls <= mag(i_job.b);
                r_mcp <= W_SQR'(mag(i_job.a));
                r_mlp <= mag(i_job.c);
                r_accs <= '0;
                r_accp <= '0;
            end
            B_MUL: begin
                if (r_mls[0]) r_accs <= r_accs + r_mcs;
                if (r_mlp[0]) r_accp <= r_accp + r_mcp;
                r_mcs <= r_mcs << 1;
                r_mcp <= r_mcp << 1;
                r_mls <= r_mls >> 1;
                r_mlp <= r_mlp >> 1;
                r_cnt <= r_cnt + 7'd1;
            end
            B_DSGN: begin
                r_rad  <= W_RAD'(w_d[W_SQR-1:0]) << (2 * Q_FRAC);
                r_root <= '0;
                r_srem <= '0;
                r_cnt  <= '0;
            end
            B_SQRT: begin
                if (w_t >= w_trial) begin
                    r_srem <= w_t - w_trial;
                    r_root <= {r_root[W_ROOT-2:0], 1'b1};
                end else begin
                    r_srem <= w_t;
                    r_root <= {r_root[W_ROOT-2:0], 1'b0};
                end
                r_rad <= r_rad << 2;
                r_cnt <= r_cnt + 7'd1;
            end
            B_NUM: begin
                r_upd  <= 1'b1;
                r_q    <= '0;
                r_drem <= w_num[W_NUM-2:0];
                r_dsh  <= W_DSH'(w_den) << Q_FRAC;
                r_cnt  <= DIV_FIRST;
            end
            B_DIV: begin
                if (w_ge) r_drem <= r_drem - {1'b0, r_dsh};
                r_q   <= {r_q[W_Q-2:0], w_ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 7'd1;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_valid       = r_ovalid;
    assign o_step_length = r_oval;

endmodule

>>> rtl/mesh_step_length_limiter_unit.sv
// ----------------------------------------------------------------------------
// mesh_step_length_limiter_unit
// Safe step length for a moving triangle mesh.
// ----------------------------------------------------------------------------
// Each item is one triangle (positions and move vectors, signed Q16.16). The
// front end takes no new triangle until it has pushed the last job: ten 33x33
// products through one multiplier build the area polynomial, then the states
// F_ABS and F_CLS classify it. A two-entry queue feeds the solver, whose time
// per triangle sets the sustained rate: an ignored triangle goes straight to
// the result update, a near-linear one runs the divider and a quadratic one
// runs the serial squarer, the square root and then the divider. After
// triangle_count triangles one item carrying half of the running minimum
// step (Q.30) is emitted and the minimum restarts at 1.0.
module mesh_step_length_limiter_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [31:0]  i_pos0_x,
    input  logic signed [31:0]  i_pos0_y,
    input  logic signed [31:0]  i_pos1_x,
    input  logic signed [31:0]  i_pos1_y,
    input  logic signed [31:0]  i_pos2_x,
    input  logic signed [31:0]  i_pos2_y,
    input  logic signed [31:0]  i_dir0_x,
    input  logic signed [31:0]  i_dir0_y,
    input  logic signed [31:0]  i_dir1_x,
    input  logic signed [31:0]  i_dir1_y,
    input  logic signed [31:0]  i_dir2_x,
    input  logic signed [31:0]  i_dir2_y,
    input  logic                i_cfg_we,
    input  logic [23:0]         i_cfg_wdata,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [29:0]         o_step_length
);
    import msl_pkg::*;

    logic   w_push, w_pop;
    t_job   w_fjob, w_qjob;
    t_qstat w_qstat;

    msl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_pos0_x (i_pos0_x),
        .i_pos0_y (i_pos0_y),
        .i_pos1_x (i_pos1_x),
        .i_pos1_y (i_pos1_y),
        .i_pos2_x (i_pos2_x),
        .i_pos2_y (i_pos2_y),
        .i_dir0_x (i_dir0_x),
        .i_dir0_y (i_dir0_y),
        .i_dir1_x (i_dir1_x),
        .i_dir1_y (i_dir1_y),
        .i_dir2_x (i_dir2_x),
        .i_dir2_y (i_dir2_y),
        .o_push   (w_push),
        .o_job    (w_fjob),
        .i_qstat  (w_qstat)
    );

    msl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .i_pop   (w_pop),
        .o_job   (w_qjob),
        .o_qstat (w_qstat)
    );

    msl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_qstat       (w_qstat),
        .i_job         (w_qjob),
        .o_pop         (w_pop),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_step_length (o_step_length)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("job popped from empty queue");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_step_length <= 30'h2000_0000))
        else $error("step length above one half");

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the mesh step length limiter: random and directed
// triangles, a bit-exact predictor of the running minimum step, random
// idling on both channels and several triangle counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import msl_pkg::*;

    typedef logic signed [255:0] wide_t;
    typedef logic signed [31:0] tri_t [12];

    class step_scoreboard;
        logic [23:0]       tri_per_result;
        logic [W_Q-1:0]    min_step;
        logic [23:0]       tri_seen;
        logic [W_OUT-1:0]  step_queue[$];
        int                errors;

        function new();
            tri_per_result = 24'd1;
            min_step       = ONE_Q30;
            tri_seen       = '0;
            errors         = 0;
        endfunction

        function void set_count(logic [23:0] n);
            tri_per_result = n;
        endfunction

        function int pending();
            return step_queue.size();
        endfunction

        function wide_t magnitude(wide_t v);
            return (v < 0) ? -v : v;
        endfunction

        function void note_triangle(tri_t t);
            wide_t px[3], py[3], mx[3], my[3];
            wide_t a, b, c, ab, bb, cb, sum, d, a2, sb, sd2, sc, lv, qw, scl;
            logic [1:0] mode;
            logic [W_Q-1:0] q, cand;
            logic ok;
            for (int k = 0; k < 3; k++) begin
                px[k] = wide_t'(t[2*k]);
                py[k] = wide_t'(t[2*k+1]);
                mx[k] = wide_t'(t[6+2*k]);
                my[k] = wide_t'(t[7+2*k]);
            end
            scl = wide_t'(ONE_Q30);
            a = (mx[1]-mx[0])*(my[2]-my[0]) - (my[1]-my[0])*(mx[2]-mx[0]);
            b = mx[0]*(py[1]-py[2]) - my[0]*(px[1]-px[2])
              + mx[1]*(py[2]-py[0]) - my[1]*(px[2]-px[0])
              + mx[2]*(py[0]-py[1]) - my[2]*(px[0]-px[1]);
            c = (px[1]-px[0])*(py[2]-py[0]) - (py[1]-py[0])*(px[2]-px[0]);
            ab = magnitude(a); bb = magnitude(b); cb = magnitude(c);
            sum = bb + cb;
            mode = MODE_NONE;
            a2 = '0; sb = '0; sd2 = '0; sc = '0;
            if (sum == 0) begin
                mode = MODE_NONE;
            end else if (ab * 10000 < sum) begin
                if (bb * 10000 < cb) mode = MODE_NONE;
                else if (c != 0 && ((c < 0) == (b < 0))) mode = MODE_NONE;
                else begin
                    mode = MODE_LIN;
                    sc = scl * cb;
                end
            end else begin
                d = b*b - 4*a*c;
                if (d >= 0) begin
                    if (a < 0) begin
                        a = -a; b = -b; c = -c;
                    end
                    if (b <= 0 && c >= 0) mode = MODE_LOW;
                    else if (b < 0 || c < 0) mode = MODE_HIGH;
                    a2 = a + a;
                    sb = scl * b;
                    sd2 = scl * scl * d;
                end
            end
            if (mode != MODE_NONE) begin
                q = '0;
                for (int bit_i = 30; bit_i >= 0; bit_i--) begin
                    cand = q | (31'd1 << bit_i);
                    if (cand <= min_step) begin
                        qw = wide_t'({1'b0, cand});
                        if (mode == MODE_LIN) begin
                            ok = (qw * bb <= sc);
                        end else begin
                            lv = a2 * qw + sb;
                            if (mode == MODE_LOW) ok = (lv <= 0) && (sd2 <= lv * lv);
                            else ok = (lv < 0) || (lv * lv <= sd2);
                        end
                        if (ok) q = cand;
                    end
                end
                if (q < min_step) min_step = q;
            end
            tri_seen = tri_seen + 24'd1;
            if (tri_seen >= tri_per_result) begin
                step_queue.push_back(min_step[W_Q-1:1]);
                min_step = ONE_Q30;
                tri_seen = '0;
            end
        endfunction

        function void check_step(logic [W_OUT-1:0] got);
            logic [W_OUT-1:0] want;
            if (step_queue.size() == 0) begin
                $error("step_length item with nothing expected, actual %0d", got);
                errors++;
                return;
            end
            want = step_queue.pop_front();
            if (got !== want) begin
                $error("step_length expected %0d actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] tri_in [12];
    logic               i_cfg_we;
    logic [23:0]        i_cfg_wdata;
    logic               o_valid;
    logic               i_stall;
    logic [29:0]        o_step_length;

    step_scoreboard sb = new();
    int stall_left;

    mesh_step_length_limiter_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_pos0_x(tri_in[0]), .i_pos0_y(tri_in[1]),
        .i_pos1_x(tri_in[2]), .i_pos1_y(tri_in[3]),
        .i_pos2_x(tri_in[4]), .i_pos2_y(tri_in[5]),
        .i_dir0_x(tri_in[6]), .i_dir0_y(tri_in[7]),
        .i_dir1_x(tri_in[8]), .i_dir1_y(tri_in[9]),
        .i_dir2_x(tri_in[10]), .i_dir2_y(tri_in[11]),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_step_length(o_step_length)
    );

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    // result side: random stall bursts, checked at each accepting edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_step(o_step_length);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else begin
            stall_left <= pick_gap();
            i_stall <= ($urandom_range(0, 1) == 1);
        end
    end

    function automatic logic signed [31:0] rand_span(int span);
        return $signed($urandom_range(0, 2*span)) - span;
    endfunction

    function automatic void make_triangle(output tri_t t);
        int kind, span;
        kind = $urandom_range(0, 9);
        span = 1 << $urandom_range(12, 22);
        for (int k = 0; k < 12; k++) t[k] = rand_span(span);
        case (kind)
            0: for (int k = 0; k < 12; k++) t[k] = $signed($urandom);
            1: for (int k = 6; k < 12; k++) t[k] = rand_span(span * 4);
            2: begin
                // pure translation: area does not change
                for (int k = 8; k < 12; k++) t[k] = t[6 + (k % 2)];
            end
            3: begin
                // collinear vertices
                t[4] = t[2] + (t[2] - t[0]);
                t[5] = t[3] + (t[3] - t[1]);
            end
            4: begin
                // only one vertex moves, straight toward vertex 0
                t[6] = 0; t[7] = 0; t[8] = 0; t[9] = 0;
                t[10] = (t[0] - t[4]) * $urandom_range(1, 4);
                t[11] = (t[1] - t[5]) * $urandom_range(1, 4);
            end
            5: for (int k = 6; k < 12; k++) t[k] = 0;
            default: ;
        endcase
    endfunction

    task automatic send_triangle(tri_t t, int gap);
        for (int k = 0; k < 12; k++) tri_in[k] <= t[k];
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        sb.note_triangle(t);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_count(logic [23:0] n);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        // triangles that complete no count may still sit in the solver
        repeat (1000) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= n;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_count(n);
    endtask

    task automatic random_phase(int n, bit no_gaps);
        tri_t t;
        for (int i = 0; i < n; i++) begin
            make_triangle(t);
            send_triangle(t, no_gaps ? 0 : pick_gap());
        end
    endtask

    task automatic directed_phase();
        tri_t t;
        for (int i = 0; i < 20; i++) begin
            for (int k = 0; k < 12; k++) t[k] = 0;
            case (i)
                0: ;
                1: for (int k = 0; k < 12; k++) t[k] = 32'sh7fff_ffff;
                2: for (int k = 0; k < 12; k++) t[k] = 32'sh8000_0000;
                3: for (int k = 0; k < 12; k++) t[k] = k[0] ? 32'sh8000_0000 : 32'sh7fff_ffff;
                4: for (int k = 0; k < 12; k++) t[k] = k[1] ? 32'sh7fff_ffff : 32'sh8000_0000;
                default: begin
                    // unit triangle, vertex 2 pushed down: linear collapse
                    t[2] = 32'sh1_0000; t[5] = 32'sh1_0000;
                    t[11] = -(32'sh1_0000 * (i - 4));
                    if (i >= 12) begin
                        // second vertex also moves: quadratic collapse
                        t[8] = -(32'sh1_0000 * (i - 11));
                        t[10] = 32'sh1_0000 * (i - 11);
                    end
                    if (i == 19) t[11] = 32'sh1_0000;
                end
            endcase
            send_triangle(t, pick_gap());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_stall = 1'b0;
        stall_left = 0;
        for (int k = 0; k < 12; k++) tri_in[k] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_phase();
        random_phase(200, 1'b0);
        write_count(24'd3);
        random_phase(250, 1'b1);
        // hold off until the block has drained
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        random_phase(250, 1'b0);
        write_count(24'd0);
        random_phase(300, 1'b0);
        write_count(24'hff_ffff);
        random_phase(10, 1'b0);
        // lowered below the triangles already seen
        write_count(24'd2);
        random_phase(400, 1'b0);
        write_count(24'd7);
        random_phase(420, 1'b0);

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("tb failed");
        $finish;
    end

endmodule

>>> mesh_step_length_limiter_unit.f
rtl/msl_pkg.sv
rtl/msl_front.sv
rtl/msl_queue.sv
rtl/msl_back.sv
rtl/mesh_step_length_limiter_unit.sv
verif/tb.sv
